// File: sv/scpg_pkg.sv
// Package for the serial-commanded PWM generator: types, character codes and scale constants.
// Has no dependencies. It is used by scpg_line_parser and serial_commanded_pwm_generator_top.
package scpg_pkg;

    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned DUTY_W   = 8;
    localparam int unsigned PROD_W   = PERIOD_W + DUTY_W;

    // The full-on duty. The duty is taken as this many parts of the period.
    localparam int unsigned       FULL_SCALE   = 250;
    localparam logic [DUTY_W-1:0] FULL_SCALE_B = DUTY_W'(FULL_SCALE);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);

    // Item kinds.
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Character codes.
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_VT    = 8'd11;
    localparam logic [7:0] CHAR_FF    = 8'd12;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_TRAIL  = 2'd2,
        PH_BAD    = 2'd3
    } parse_phase_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_ACCEPT = 2'd1,
        EV_REJECT = 2'd2
    } line_ev_t;

    // What the line parser reports for the byte that is being taken.
    typedef struct packed {
        logic              duty_load;
        logic [DUTY_W-1:0] duty_val;
        line_ev_t          line_ev;
    } parse_result_t;

endpackage

// File: sv/scpg_line_parser.sv
// Command line parser: trims white space, accumulates decimal digits and saturates the value.
// Depends on scpg_pkg.
module scpg_line_parser
    import scpg_pkg::*;
#(
    parameter int unsigned MAX_LINE_CHARS = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          byte_take,
    input  logic [7:0]    rx_byte,
    output parse_result_t result
);

    localparam int unsigned LEN_W = $clog2(MAX_LINE_CHARS + 1);
    localparam logic [LEN_W:0] LEN_LIMIT = (LEN_W + 1)'(MAX_LINE_CHARS);

    logic [LEN_W-1:0]  len_reg, len_next;
    parse_phase_t      phase_reg, phase_next;
    logic [DUTY_W-1:0] acc_reg, acc_next;

    logic              is_lf, is_cr, is_blank, is_digit;
    logic [3:0]        digit_val;
    logic [11:0]       acc_sum;
    logic [DUTY_W-1:0] acc_sat;
    logic [LEN_W:0]    len_inc;

    always_comb begin
        is_lf     = (rx_byte == CHAR_LF);
        is_cr     = (rx_byte == CHAR_CR);
        is_blank  = (rx_byte == CHAR_SPACE) || (rx_byte == CHAR_TAB) ||
                    (rx_byte == CHAR_VT) || (rx_byte == CHAR_FF);
        is_digit  = rx_byte inside {[CHAR_ZERO:CHAR_NINE]};
        digit_val = 4'(rx_byte - CHAR_ZERO);
        acc_sum   = (12'(acc_reg) << 3) + (12'(acc_reg) << 1) + 12'(digit_val);
        acc_sat   = (acc_sum > 12'(FULL_SCALE)) ? FULL_SCALE_B : acc_sum[DUTY_W-1:0];
        len_inc   = (LEN_W + 1)'(len_reg) + (LEN_W + 1)'(1);
    end

    always_comb begin
        len_next         = len_reg;
        phase_next       = phase_reg;
        acc_next         = acc_reg;
        result.duty_load = 1'b0;
        result.duty_val  = acc_reg;
        result.line_ev   = EV_NONE;

        if (byte_take) begin
            if (is_lf) begin
                case (phase_reg)
                    PH_DIGITS, PH_TRAIL: begin
                        result.duty_load = 1'b1;
                        result.line_ev   = EV_ACCEPT;
                    end
                    PH_BAD: begin
                        result.line_ev = EV_REJECT;
                    end
                    default: begin
                    end
                endcase
                len_next   = '0;
                phase_next = PH_LEAD;
                acc_next   = '0;
            end else if (!is_cr) begin
                if (len_inc > LEN_LIMIT) begin
                    // The line has grown too long: drop it together with this character.
                    len_next   = '0;
                    phase_next = PH_LEAD;
                    acc_next   = '0;
                end else begin
                    len_next = len_inc[LEN_W-1:0];
                    if (is_blank) begin
                        if (phase_reg == PH_DIGITS) begin
                            phase_next = PH_TRAIL;
                        end
                    end else if (is_digit) begin
                        if (phase_reg == PH_LEAD || phase_reg == PH_DIGITS) begin
                            acc_next   = acc_sat;
                            phase_next = PH_DIGITS;
                        end else begin
                            phase_next = PH_BAD;
                        end
                    end else begin
                        phase_next = PH_BAD;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            phase_reg <= PH_LEAD;
            acc_reg   <= '0;
        end else begin
            len_reg   <= len_next;
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (LEN_W + 1)'(len_reg) <= LEN_LIMIT)
        else $error("line length beyond the limit");
    a_acc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg <= FULL_SCALE_B)
        else $error("digit accumulator not saturated");
    a_load_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        result.duty_load |-> (byte_take && is_lf &&
                              (phase_reg == PH_DIGITS || phase_reg == PH_TRAIL)))
        else $error("duty loaded without a finished number");
`endif

endmodule

// File: sv/serial_commanded_pwm_generator_top.sv
// Top level of the serial-commanded PWM generator: PWM phase counter, duty and result register.
// Depends on scpg_pkg and scpg_line_parser.
//
//  Channel   Direction  Ports                                       Request
//  s_        in         s_valid s_ready s_func s_rx_byte            one byte or one tick
//  m_        out        m_valid m_ready m_pwm_level m_duty_now      one result per input
//                       m_line_event
//  cfg_      in         cfg_valid cfg_ready cfg_period_ticks        period write
//
//  Each request is handled combinationally and its result is held in the output register.
//  A new request is accepted in every cycle in which the output register is empty or is
//  being emptied, so the block sustains one request per clock.
//  A stall on m_ready holds the result and blocks further requests after that one.
//  Reset (aresetn low at a clock edge) sets the period to 1000 ticks, the duty and phase
//  to zero and the line parser to an empty line. The configuration port is always ready.
module serial_commanded_pwm_generator_top
    import scpg_pkg::*;
#(
    parameter int unsigned MAX_LINE_CHARS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic [7:0]          s_rx_byte,

    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_pwm_level,
    output logic [DUTY_W-1:0]   m_duty_now,
    output logic [1:0]          m_line_event,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PERIOD_W-1:0] cfg_period_ticks
);

    // Step of the scaled phase: FULL_SCALE for each tick.
    localparam logic [PROD_W-1:0] SCALE_STEP = PROD_W'(FULL_SCALE);

    logic [PERIOD_W-1:0] period_reg;
    logic [DUTY_W-1:0]   duty_reg, duty_next;
    logic [PERIOD_W-1:0] phase_reg, phase_next;
    // thr_reg always holds FULL_SCALE * (phase + 1). The level is high while
    // phase < period * duty / FULL_SCALE, which is the same as thr <= period * duty,
    // so no divider is needed.
    logic [PROD_W-1:0]   thr_reg, thr_next;

    logic                m_valid_reg;
    logic                level_reg;
    logic [DUTY_W-1:0]   duty_out_reg;
    logic [1:0]          event_reg;

    logic                s_accept, tick_take, byte_take;
    logic [PERIOD_W:0]   phase_inc;
    logic                wrap;
    logic [PROD_W-1:0]   on_prod;
    logic                level_next;
    parse_result_t       parse;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign tick_take = s_accept && (s_func == FUNC_TICK);
    assign byte_take = s_accept && (s_func == FUNC_BYTE);
    assign cfg_ready = 1'b1;

    scpg_line_parser #(
        .MAX_LINE_CHARS (MAX_LINE_CHARS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_take (byte_take),
        .rx_byte   (s_rx_byte),
        .result    (parse)
    );

    always_comb begin
        phase_inc  = (PERIOD_W + 1)'(phase_reg) + (PERIOD_W + 1)'(1);
        wrap       = (phase_inc >= (PERIOD_W + 1)'(period_reg));
        phase_next = phase_reg;
        thr_next   = thr_reg;
        if (tick_take) begin
            if (wrap) begin
                phase_next = '0;
                thr_next   = SCALE_STEP;
            end else begin
                phase_next = phase_inc[PERIOD_W-1:0];
                thr_next   = thr_reg + SCALE_STEP;
            end
        end
        duty_next  = parse.duty_load ? parse.duty_val : duty_reg;
        on_prod    = PROD_W'(period_reg) * PROD_W'(duty_next);
        level_next = (thr_next <= on_prod);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= PERIOD_RESET;
            duty_reg    <= '0;
            phase_reg   <= '0;
            thr_reg     <= SCALE_STEP;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                period_reg <= cfg_period_ticks;
            end
            if (s_accept) begin
                duty_reg    <= duty_next;
                phase_reg   <= phase_next;
                thr_reg     <= thr_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: loaded on every accepted request, held while the consumer stalls.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            level_reg    <= level_next;
            duty_out_reg <= duty_next;
            event_reg    <= parse.line_ev;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pwm_level  = level_reg;
    assign m_duty_now   = duty_out_reg;
    assign m_line_event = event_reg;

`ifndef NO_ASSERTIONS
    a_thr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        thr_reg == SCALE_STEP * (PROD_W'(phase_reg) + PROD_W'(1)))
        else $error("scaled phase out of step with the phase counter");
    a_tick_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_take |=> (m_line_event == EV_NONE))
        else $error("line event reported on a tick");
    a_zero_period: assert property (@(posedge aclk) disable iff (!aresetn)
        (tick_take && period_reg == '0) |=> (phase_reg == '0 && !m_pwm_level))
        else $error("phase or level moved with a zero period");
    a_duty_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_duty_now <= FULL_SCALE_B))
        else $error("duty above full scale");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for serial_commanded_pwm_generator_top: a directed table, then random
// command lines mixed with ticks over several period settings. Depends on scpg_pkg and the RTL.
module tb
    import scpg_pkg::*;
();

    localparam int MAX_LINE     = 32;
    localparam int RANDOM_ITEMS = 1250;
    localparam int PHASES       = 8;
    localparam int DIR_ROWS     = 27;

    typedef int unsigned uint_t;

    // One result as the block should present it.
    typedef struct packed {
        logic              level;
        logic [DUTY_W-1:0] duty;
        line_ev_t          ev;
    } drive_t;

    // One row of the directed table. Where typed is set, want is the result to check against.
    typedef struct packed {
        logic       func;
        logic [7:0] code;
        logic       typed;
        drive_t     want;
    } dir_row_t;

    logic                aclk             = 1'b0;
    logic                aresetn          = 1'b0;
    logic                s_valid          = 1'b0;
    logic                s_ready;
    logic                s_func           = FUNC_BYTE;
    logic [7:0]          s_rx_byte        = 8'd0;
    logic                m_valid;
    logic                m_ready          = 1'b0;
    logic                m_pwm_level;
    logic [DUTY_W-1:0]   m_duty_now;
    logic [1:0]          m_line_event;
    logic                cfg_valid        = 1'b0;
    logic                cfg_ready;
    logic [PERIOD_W-1:0] cfg_period_ticks = '0;

    // Predicted state of the generator.
    logic [PERIOD_W-1:0] cur_period;
    logic [DUTY_W-1:0]   cur_duty;
    logic [PERIOD_W-1:0] cur_phase;
    logic [5:0]          line_chars;
    parse_phase_t        line_state;
    logic [DUTY_W-1:0]   line_value;

    drive_t   drive_due[$];
    drive_t   got_want;
    dir_row_t dir_table [0:DIR_ROWS-1];
    int       bad_count  = 0;
    int       items_done = 0;
    int       hold_left  = 0;
    int       tick_pct   = 35;
    bit       idle_on    = 1'b0;

    serial_commanded_pwm_generator_top #(
        .MAX_LINE_CHARS (MAX_LINE)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pwm_level      (m_pwm_level),
        .m_duty_now       (m_duty_now),
        .m_line_event     (m_line_event),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_period_ticks (cfg_period_ticks)
    );

    // 8 ns clock, low then high.
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Starts an empty command line in the predictor.
    function automatic void forget_line();
        line_chars = '0;
        line_state = PH_LEAD;
        line_value = '0;
    endfunction

    // Advances the predicted state by one request and returns the result it should produce.
    function automatic drive_t next_drive(input logic f, input logic [7:0] c);
        drive_t r;
        uint_t  sum;
        uint_t  on_ticks;
        r.ev = EV_NONE;
        if (f == FUNC_TICK) begin
            sum = uint_t'(cur_phase) + 1;
            cur_phase = (sum >= uint_t'(cur_period)) ? '0 : PERIOD_W'(sum);
        end else if (c == CHAR_LF) begin
            if (line_state == PH_DIGITS || line_state == PH_TRAIL) begin
                cur_duty = line_value;
                r.ev = EV_ACCEPT;
            end else if (line_state == PH_BAD) begin
                r.ev = EV_REJECT;
            end
            forget_line();
        end else if (c != CHAR_CR) begin
            // A character that would overfill the line throws the whole line away.
            if (int'(line_chars) + 1 > MAX_LINE) begin
                forget_line();
            end else begin
                line_chars = line_chars + 6'd1;
                if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF) begin
                    if (line_state == PH_DIGITS)
                        line_state = PH_TRAIL;
                end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                    if (line_state == PH_LEAD || line_state == PH_DIGITS) begin
                        sum = uint_t'(line_value) * 10 + uint_t'(c - CHAR_ZERO);
                        line_value = (sum > FULL_SCALE) ? FULL_SCALE_B : DUTY_W'(sum);
                        line_state = PH_DIGITS;
                    end else begin
                        line_state = PH_BAD;
                    end
                end else begin
                    line_state = PH_BAD;
                end
            end
        end
        on_ticks = (uint_t'(cur_period) * uint_t'(cur_duty)) / FULL_SCALE;
        r.level  = (uint_t'(cur_phase) < on_ticks);
        r.duty   = cur_duty;
        return r;
    endfunction

    // Idle length: mostly none, some short, a few long.
    function automatic int idle_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] any_blank();
        case ($urandom_range(0, 3))
            0: return CHAR_SPACE;
            1: return CHAR_TAB;
            2: return CHAR_VT;
            default: return CHAR_FF;
        endcase
    endfunction

    function automatic logic [7:0] any_digit();
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Any byte that is neither white space, a digit, CR nor newline.
    function automatic logic [7:0] any_stray();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF ||
                   c == CHAR_CR || c == CHAR_LF || (c >= CHAR_ZERO && c <= CHAR_NINE));
        return c;
    endfunction

    // Offers one request, waits for it to be taken and records the result it should cause.
    // Entered and left at a falling edge; valid is left high so that a following request
    // can be offered back to back.
    task automatic send_item(input logic f, input logic [7:0] c, input logic typed,
                             input drive_t want);
        int     gap;
        drive_t got;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_func    <= f;
        s_rx_byte <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        got = next_drive(f, c);
        drive_due.push_back(typed ? want : got);
        if (!(f == FUNC_BYTE && c == CHAR_CR))
            items_done++;
        @(negedge aclk);
    endtask

    // Sends one character, sometimes preceded by a few ticks.
    task automatic put_char(input logic [7:0] c);
        if ($urandom_range(0, 99) < tick_pct)
            repeat ($urandom_range(1, 3))
                send_item(FUNC_TICK, 8'($urandom_range(0, 255)), 1'b0, '0);
        send_item(FUNC_BYTE, c, 1'b0, '0);
    endtask

    // A line of digits framed by white space. A spoil of 1 puts a stray character after the
    // digits, a spoil of 2 a digit after the trailing white space.
    task automatic send_number_line(input int spoil);
        int ndig;
        repeat ($urandom_range(0, 3)) put_char(any_blank());
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4)) put_char(CHAR_ZERO);
        ndig = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 9) : $urandom_range(1, 3);
        repeat (ndig) begin
            if ($urandom_range(0, 9) == 0)
                put_char(CHAR_CR);
            put_char(any_digit());
        end
        if (spoil == 1)
            put_char(any_stray());
        repeat ($urandom_range(0, 2)) put_char(any_blank());
        if (spoil == 2) begin
            put_char(any_blank());
            put_char(any_digit());
        end
        if ($urandom_range(0, 2) == 0)
            put_char(CHAR_CR);
        put_char(CHAR_LF);
    endtask

    // A line of digits and white space near or past the length limit.
    task automatic send_long_line(input int n);
        repeat (n) put_char($urandom_range(0, 1) ? any_digit() : any_blank());
        put_char(CHAR_LF);
    endtask

    task automatic send_line();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            send_number_line(0);
        end else if (pick < 77) begin
            send_number_line($urandom_range(1, 2));
        end else if (pick < 85) begin
            send_long_line($urandom_range(30, 40));
        end else if (pick < 92) begin
            repeat ($urandom_range(0, 3)) put_char(any_blank());
            put_char(CHAR_LF);
        end else begin
            // Noise: arbitrary bytes, not always closed by a newline.
            repeat ($urandom_range(1, 6)) put_char(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 1)
                put_char(CHAR_LF);
        end
    endtask

    // Writes the period once every outstanding result has come out.
    task automatic set_period(input logic [PERIOD_W-1:0] v);
        s_valid <= 1'b0;
        while (drive_due.size() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
        cfg_valid        <= 1'b1;
        cfg_period_ticks <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cur_period = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random back-pressure, plus one long hold-off when asked for. The hold-off
    // is counted here so that the sender keeps offering requests and the block fills up.
    initial begin : result_side
        int gap_left;
        gap_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (gap_left > 0) begin
                m_ready <= 1'b0;
                gap_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    gap_left = idle_gap();
            end
        end
    end

    // Every result taken is compared, field by field, with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (drive_due.size() == 0) begin
                $display("%0t: result with none pending: level %0b duty %0d event %0d",
                         $time, m_pwm_level, m_duty_now, m_line_event);
                bad_count++;
            end else begin
                got_want = drive_due.pop_front();
                if (m_pwm_level !== got_want.level) begin
                    $display("%0t: pwm_level expected %0b actual %0b",
                             $time, got_want.level, m_pwm_level);
                    bad_count++;
                end
                if (m_duty_now !== got_want.duty) begin
                    $display("%0t: duty_now expected %0d actual %0d",
                             $time, got_want.duty, m_duty_now);
                    bad_count++;
                end
                if (m_line_event !== got_want.ev) begin
                    $display("%0t: line_event expected %0d actual %0d",
                             $time, got_want.ev, m_line_event);
                    bad_count++;
                end
            end
        end
    end

    initial begin : stimulus
        logic [PERIOD_W-1:0] periods [0:PHASES-1];
        int                  goal;

        // Directed table. The opening rows follow the reset state; later rows walk through
        // saturation, CR, white space of each kind, a stray character, blank and empty lines,
        // a digit after trailing white space and a top-bit byte.
        dir_table = '{
            '{FUNC_TICK, 8'h00,            1'b1, '{1'b0, 8'd0,   EV_NONE}},
            '{FUNC_BYTE, CHAR_ZERO + 8'd2, 1'b0, '0},
            '{FUNC_BYTE, CHAR_ZERO + 8'd5, 1'b0, '0},
            '{FUNC_BYTE, CHAR_ZERO + 8'd5, 1'b0, '0},
            '{FUNC_BYTE, CHAR_CR,          1'b0, '0},
            '{FUNC_BYTE, CHAR_LF,          1'b1, '{1'b1, 8'd250, EV_ACCEPT}},
            '{FUNC_TICK, 8'hFF,            1'b0, '0},
            '{FUNC_BYTE, CHAR_SPACE,       1'b0, '0},
            '{FUNC_BYTE, CHAR_TAB,         1'b0, '0},
            '{FUNC_BYTE, CHAR_ZERO,        1'b0, '0},
            '{FUNC_BYTE, CHAR_ZERO + 8'd7, 1'b0, '0},
            '{FUNC_BYTE, CHAR_VT,          1'b0, '0},
            '{FUNC_BYTE, CHAR_FF,          1'b0, '0},
            '{FUNC_BYTE, CHAR_LF,          1'b0, '0},
            '{FUNC_BYTE, 8'd65,            1'b0, '0},
            '{FUNC_BYTE, CHAR_LF,          1'b1, '{1'b1, 8'd7,   EV_REJECT}},
            '{FUNC_BYTE, CHAR_SPACE,       1'b0, '0},
            '{FUNC_BYTE, CHAR_LF,          1'b0, '0},
            '{FUNC_BYTE, CHAR_LF,          1'b0, '0},
            '{FUNC_BYTE, CHAR_ZERO + 8'd1, 1'b0, '0},
            '{FUNC_BYTE, CHAR_SPACE,       1'b0, '0},
            '{FUNC_BYTE, CHAR_ZERO + 8'd2, 1'b0, '0},
            '{FUNC_BYTE, CHAR_LF,          1'b1, '{1'b1, 8'd7,   EV_REJECT}},
            '{FUNC_BYTE, 8'hFF,            1'b0, '0},
            '{FUNC_BYTE, CHAR_LF,          1'b0, '0},
            '{FUNC_BYTE, CHAR_ZERO,        1'b0, '0},
            '{FUNC_BYTE, CHAR_LF,          1'b1, '{1'b0, 8'd0,   EV_ACCEPT}}
        };

        // The second setting leaves the phase far above the third, which lowers the period
        // under it. Zero and both ends of the range are among the settings.
        periods = '{16'd1, 16'd65535, 16'd5, 16'd0, 16'd2,
                    PERIOD_W'($urandom_range(1, 65535)), 16'd250, PERIOD_RESET};

        cur_period = PERIOD_RESET;
        cur_duty   = '0;
        cur_phase  = '0;
        forget_line();

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        idle_on = 1'b1;
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_table[i].func, dir_table[i].code, dir_table[i].typed,
                      dir_table[i].want);

        for (int ph = 0; ph < PHASES; ph++) begin
            set_period(periods[ph]);
            idle_on  = (ph != 0 && ph != 4);
            tick_pct = (ph == 1) ? 75 : 35;
            if (ph == 2)
                hold_left = 300;
            goal = items_done + RANDOM_ITEMS / PHASES;
            // The first random line always overflows the length limit.
            if (ph == 0)
                send_long_line(MAX_LINE + 1);
            while (items_done < goal)
                send_line();
        end
        s_valid <= 1'b0;

        while (drive_due.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (bad_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Worst case, with both sides idling their longest, is about 1.4 ms for the whole run;
    // this allows several times that.
    initial begin : watchdog
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
